@@ sv/gcode_line_command_parser_defines.svh @@
// Assertion macros shared by the command line parser.
`ifndef GCODE_LINE_COMMAND_PARSER_DEFINES_SVH
`define GCODE_LINE_COMMAND_PARSER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define GLCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define GLCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/glcp_pkg.sv @@
// Types, codes and character helpers for the command line parser.
package glcp_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int ARG_BITS = 32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D1    = 8'h31;
  localparam logic [7:0] CH_D2    = 8'h32;
  localparam logic [7:0] CH_D4    = 8'h34;
  localparam logic [7:0] CH_D8    = 8'h38;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;

  typedef enum logic [2:0] {
    CMD_CALIBRATE = 3'd0,
    CMD_ORIGIN    = 3'd1,
    CMD_LIMIT     = 3'd2,
    CMD_MOVE      = 3'd3,
    CMD_STATUS    = 3'd4,
    CMD_PEN_RANGE = 3'd5,
    CMD_PEN       = 3'd6,
    CMD_LASER     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_BAD_NUM   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    NS_LEAD = 3'd0,
    NS_SIGN = 3'd1,
    NS_DIGS = 3'd2,
    NS_STOP = 3'd3,
    NS_BAD  = 3'd4
  } num_st_t;

  typedef enum logic [3:0] {
    PR_WS1  = 4'd0,
    PR_UWS  = 4'd1,
    PR_USGN = 4'd2,
    PR_UDIG = 4'd3,
    PR_WS2  = 4'd4,
    PR_DWS  = 4'd5,
    PR_DSGN = 4'd6,
    PR_DDIG = 4'd7,
    PR_DONE = 4'd8,
    PR_FAIL = 4'd15
  } pr_t;

  typedef enum logic [1:0] {
    MV_SEEK_X = 2'd0,
    MV_X_DIGS = 2'd1,
    MV_SEEK_Y = 2'd2,
    MV_Y_DIGS = 2'd3
  } move_ph_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic [2:0]                 cmd_type;
    logic [1:0]                 status;
    logic signed [ARG_BITS-1:0] arg_a;
    logic signed [ARG_BITS-1:0] arg_b;
  } result_t;

  // Per-beat control from the top level to the parsers.
  typedef struct packed {
    logic       step;
    logic       clear;
    logic [7:0] ch;
  } step_ctl_t;

  typedef struct packed {
    logic                       bad;
    logic signed [ARG_BITS-1:0] value;
  } num_report_t;

  typedef struct packed {
    logic                       malformed;
    logic                       bad;
    logic signed [ARG_BITS-1:0] up;
    logic signed [ARG_BITS-1:0] down;
  } pen_report_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

endpackage

@@ sv/glcp_digit_acc.sv @@
// Decimal digit accumulate with overflow flag, plus value and range check.
module glcp_digit_acc #(
  parameter int VALUE_BITS = glcp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic [VALUE_BITS-1:0]                mag,
  input  logic                                 ovf,
  input  logic                                 neg,
  input  logic [7:0]                           ch,
  output logic [VALUE_BITS-1:0]                mag_next,
  output logic                                 ovf_next,
  output logic signed [glcp_pkg::ARG_BITS-1:0] value,
  output logic                                 range_bad
);
  import glcp_pkg::*;

  localparam int W   = VALUE_BITS;
  localparam int EXT = (W > ARG_BITS) ? W : ARG_BITS;
  localparam logic [W-1:0] LIMIT = {1'b1, {(W-1){1'b0}}};

  logic [W+3:0]  prod;
  logic          over;
  logic [EXT-1:0] ext;
  logic [EXT-1:0] signed_ext;

  // mag*10 + d exceeds the negative limit exactly when the digit would overflow
  assign prod = {3'b000, mag, 1'b0} + {1'b0, mag, 3'b000} + {{W{1'b0}}, ch[3:0]};
  assign over = prod > {4'b0000, LIMIT};

  always_comb begin
    mag_next = mag;
    ovf_next = ovf;
    if (!ovf) begin
      if (over) begin
        ovf_next = 1'b1;
      end else begin
        mag_next = prod[W-1:0];
      end
    end
  end

  assign ext        = EXT'(mag);
  assign signed_ext = neg ? (~ext + {{(EXT-1){1'b0}}, 1'b1}) : ext;
  assign value      = signed_ext[ARG_BITS-1:0];
  assign range_bad  = ovf || (!neg && (mag >= LIMIT));

endmodule

@@ sv/glcp_number.sv @@
// Free-form signed integer scanner: whitespace, sign, digits, stop.
module glcp_number #(
  parameter int VALUE_BITS = glcp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  glcp_pkg::step_ctl_t    ctl,
  input  logic                   feed,
  output glcp_pkg::num_report_t  report
);
  import glcp_pkg::*;

  num_st_t                    st, st_next;
  logic                       neg, neg_next;
  logic                       ovf, ovf_next;
  logic [VALUE_BITS-1:0]      mag, mag_next;
  logic [VALUE_BITS-1:0]      dig_mag;
  logic                       dig_ovf;
  logic                       range_bad;
  logic signed [ARG_BITS-1:0] value;

  glcp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_digit (
    .mag       (mag),
    .ovf       (ovf),
    .neg       (neg),
    .ch        (ctl.ch),
    .mag_next  (dig_mag),
    .ovf_next  (dig_ovf),
    .value     (value),
    .range_bad (range_bad)
  );

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      st  <= NS_LEAD;
      neg <= 1'b0;
      ovf <= 1'b0;
      mag <= '0;
    end else if (ctl.step && feed) begin
      st  <= st_next;
      neg <= neg_next;
      ovf <= ovf_next;
      mag <= mag_next;
    end
  end

  always_comb begin
    st_next  = st;
    neg_next = neg;
    ovf_next = ovf;
    mag_next = mag;
    unique case (st)
      NS_LEAD: begin
        if (is_ws(ctl.ch)) begin
          st_next = NS_LEAD;
        end else if ((ctl.ch == CH_PLUS) || (ctl.ch == CH_MINUS)) begin
          neg_next = (ctl.ch == CH_MINUS);
          st_next  = NS_SIGN;
        end else if (is_dig(ctl.ch)) begin
          mag_next = dig_mag;
          ovf_next = dig_ovf;
          st_next  = NS_DIGS;
        end else begin
          st_next = NS_BAD;
        end
      end
      NS_SIGN: begin
        if (is_dig(ctl.ch)) begin
          mag_next = dig_mag;
          ovf_next = dig_ovf;
          st_next  = NS_DIGS;
        end else begin
          st_next = NS_BAD;
        end
      end
      NS_DIGS: begin
        if (is_dig(ctl.ch)) begin
          mag_next = dig_mag;
          ovf_next = dig_ovf;
        end else begin
          st_next = NS_STOP;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  assign report = '{bad:   ((st != NS_DIGS) && (st != NS_STOP)) || range_bad,
                    value: value};

endmodule

@@ sv/glcp_pen_range.sv @@
// Pattern matcher for the pen range fields: U value then D value.
module glcp_pen_range #(
  parameter int VALUE_BITS = glcp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  glcp_pkg::step_ctl_t   ctl,
  input  logic                  feed,
  output glcp_pkg::pen_report_t report
);
  import glcp_pkg::*;

  pr_t                        phase, phase_next;
  logic                       up_neg, up_neg_next, dn_neg, dn_neg_next;
  logic                       up_ovf, up_ovf_next, dn_ovf, dn_ovf_next;
  logic [VALUE_BITS-1:0]      up_mag, up_mag_next, dn_mag, dn_mag_next;
  logic [VALUE_BITS-1:0]      up_dig_mag, dn_dig_mag;
  logic                       up_dig_ovf, dn_dig_ovf;
  logic                       up_bad, dn_bad;
  logic                       c_ws, c_dig, c_sign;
  logic signed [ARG_BITS-1:0] up_value, dn_value;

  glcp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_up (
    .mag       (up_mag),
    .ovf       (up_ovf),
    .neg       (up_neg),
    .ch        (ctl.ch),
    .mag_next  (up_dig_mag),
    .ovf_next  (up_dig_ovf),
    .value     (up_value),
    .range_bad (up_bad)
  );

  glcp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_down (
    .mag       (dn_mag),
    .ovf       (dn_ovf),
    .neg       (dn_neg),
    .ch        (ctl.ch),
    .mag_next  (dn_dig_mag),
    .ovf_next  (dn_dig_ovf),
    .value     (dn_value),
    .range_bad (dn_bad)
  );

  assign c_ws   = is_ws(ctl.ch);
  assign c_dig  = is_dig(ctl.ch);
  assign c_sign = (ctl.ch == CH_PLUS) || (ctl.ch == CH_MINUS);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      phase  <= PR_WS1;
      up_neg <= 1'b0;
      up_ovf <= 1'b0;
      up_mag <= '0;
      dn_neg <= 1'b0;
      dn_ovf <= 1'b0;
      dn_mag <= '0;
    end else if (ctl.step && feed) begin
      phase  <= phase_next;
      up_neg <= up_neg_next;
      up_ovf <= up_ovf_next;
      up_mag <= up_mag_next;
      dn_neg <= dn_neg_next;
      dn_ovf <= dn_ovf_next;
      dn_mag <= dn_mag_next;
    end
  end

  always_comb begin
    phase_next  = phase;
    up_neg_next = up_neg;
    up_ovf_next = up_ovf;
    up_mag_next = up_mag;
    dn_neg_next = dn_neg;
    dn_ovf_next = dn_ovf;
    dn_mag_next = dn_mag;
    unique case (phase)
      PR_WS1: begin
        if (ctl.ch == CH_U) phase_next = PR_UWS;
        else if (!c_ws) phase_next = PR_FAIL;
      end
      PR_UWS: begin
        if (c_ws) begin
          phase_next = PR_UWS;
        end else if (c_sign) begin
          up_neg_next = (ctl.ch == CH_MINUS);
          phase_next  = PR_USGN;
        end else if (c_dig) begin
          up_mag_next = up_dig_mag;
          up_ovf_next = up_dig_ovf;
          phase_next  = PR_UDIG;
        end else begin
          phase_next = PR_FAIL;
        end
      end
      PR_USGN: begin
        if (c_dig) begin
          up_mag_next = up_dig_mag;
          up_ovf_next = up_dig_ovf;
          phase_next  = PR_UDIG;
        end else begin
          phase_next = PR_FAIL;
        end
      end
      PR_UDIG: begin
        if (c_dig) begin
          up_mag_next = up_dig_mag;
          up_ovf_next = up_dig_ovf;
        end else if (c_ws) begin
          phase_next = PR_WS2;
        end else if (ctl.ch == CH_D) begin
          phase_next = PR_DWS;
        end else begin
          phase_next = PR_FAIL;
        end
      end
      PR_WS2: begin
        if (ctl.ch == CH_D) phase_next = PR_DWS;
        else if (!c_ws) phase_next = PR_FAIL;
      end
      PR_DWS: begin
        if (c_ws) begin
          phase_next = PR_DWS;
        end else if (c_sign) begin
          dn_neg_next = (ctl.ch == CH_MINUS);
          phase_next  = PR_DSGN;
        end else if (c_dig) begin
          dn_mag_next = dn_dig_mag;
          dn_ovf_next = dn_dig_ovf;
          phase_next  = PR_DDIG;
        end else begin
          phase_next = PR_FAIL;
        end
      end
      PR_DSGN: begin
        if (c_dig) begin
          dn_mag_next = dn_dig_mag;
          dn_ovf_next = dn_dig_ovf;
          phase_next  = PR_DDIG;
        end else begin
          phase_next = PR_FAIL;
        end
      end
      PR_DDIG: begin
        if (c_dig) begin
          dn_mag_next = dn_dig_mag;
          dn_ovf_next = dn_dig_ovf;
        end else begin
          phase_next = PR_DONE;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  assign report = '{malformed: (phase != PR_DDIG) && (phase != PR_DONE),
                    bad:       up_bad || dn_bad,
                    up:        up_value,
                    down:      dn_value};

endmodule

@@ sv/gcode_line_command_parser.sv @@
// Top level of the G-code command line parser: input stage, scanners, result register.
//
// The block takes a command line one character per beat and, on the beat that
// carries line_end, gives one decoded command (type, status and up to two
// signed 32-bit arguments), then clears itself for the next line. Character
// beats give no result. A beat is held in the input register, passes through
// the prefix capture, the G1 coordinate scanners, the M2 pen range matcher and
// the M1/M4 integer scanner side by side (each of the scanners a decode plus
// multiply-by-ten accumulate logic), and the end of line beat writes the
// result register. Character beats advance every cycle whatever the result
// register holds; only an end of line beat waits in the input register, and
// only while the previous result still waits for result_ready, so a finished
// result waiting at the output does not stall the characters of the next line
// until that line ends. From the input register the line_end beat loads the
// result register, which raises result_valid, once the previous result has
// been taken. Numbers are held in VALUE_BITS bits and flagged as bad when they
// leave the signed VALUE_BITS range; arguments are always reported in 32 bits.
`include "gcode_line_command_parser_defines.svh"

module gcode_line_command_parser #(
  parameter int VALUE_BITS = glcp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  glcp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output glcp_pkg::result_t result
);
  import glcp_pkg::*;

  // Input stage
  logic      s1_valid;
  item_t     s1_item;
  logic      adv;
  step_ctl_t ctl;

  // Line state
  logic [1:0] char_index;
  logic [7:0] prefix [3];
  move_ph_t   move_phase, move_phase_next;
  logic       move_done, move_done_next;
  logic       x_feed, y_feed;
  logic       late_feed;

  num_report_t x_rep, y_rep, single_rep;
  pen_report_t pen_rep;

  logic    p_m28, p_g28, p_m11, p_g1, p_m10, p_m2, p_m1, p_m4;
  result_t res_next;

  // Advance characters every cycle; hold an end of line beat until the
  // result register can take it.
  assign adv        = s1_valid && (!s1_item.line_end || !result_valid || result_ready);
  assign item_ready = !s1_valid || adv;

  assign ctl = '{step:  adv && !s1_item.line_end,
                 clear: adv && s1_item.line_end,
                 ch:    s1_item.ch};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  // Capture the first three characters and keep a saturating count.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      char_index <= 2'd0;
      prefix[0]  <= 8'h00;
      prefix[1]  <= 8'h00;
      prefix[2]  <= 8'h00;
    end else if (ctl.step) begin
      if (char_index != 2'd3) begin
        prefix[char_index] <= ctl.ch;
        char_index         <= char_index + 2'd1;
      end
    end
  end

  // G1 scan: seek X, take its digits up to a space, then the same for Y.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      move_phase <= MV_SEEK_X;
      move_done  <= 1'b0;
    end else if (ctl.step) begin
      move_phase <= move_phase_next;
      move_done  <= move_done_next;
    end
  end

  always_comb begin
    move_phase_next = move_phase;
    move_done_next  = move_done;
    x_feed          = 1'b0;
    y_feed          = 1'b0;
    if (!move_done) begin
      unique case (move_phase)
        MV_SEEK_X: begin
          if (ctl.ch == CH_X) move_phase_next = MV_X_DIGS;
        end
        MV_X_DIGS: begin
          if (ctl.ch == CH_SPACE) move_phase_next = MV_SEEK_Y;
          else if (ctl.ch != CH_DOT) x_feed = 1'b1;
        end
        MV_SEEK_Y: begin
          if (ctl.ch == CH_Y) move_phase_next = MV_Y_DIGS;
        end
        MV_Y_DIGS: begin
          if (ctl.ch == CH_SPACE) move_done_next = 1'b1;
          else if (ctl.ch != CH_DOT) y_feed = 1'b1;
        end
        default: begin
          move_phase_next = move_phase;
        end
      endcase
    end
  end

  glcp_number #(.VALUE_BITS(VALUE_BITS)) u_move_x (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .feed   (x_feed),
    .report (x_rep)
  );

  glcp_number #(.VALUE_BITS(VALUE_BITS)) u_move_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .feed   (y_feed),
    .report (y_rep)
  );

  // Argument parsers for M1, M4 and M2 start at the third character.
  assign late_feed = char_index[1];

  glcp_number #(.VALUE_BITS(VALUE_BITS)) u_single (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .feed   (late_feed),
    .report (single_rep)
  );

  glcp_pen_range #(.VALUE_BITS(VALUE_BITS)) u_pen_range (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .feed   (late_feed),
    .report (pen_rep)
  );

  // Prefix matches; a prefix needs at least as many characters as it has.
  assign p_m28 = (char_index == 2'd3) && (prefix[0] == CH_M) && (prefix[1] == CH_D2)
                 && (prefix[2] == CH_D8);
  assign p_g28 = (char_index == 2'd3) && (prefix[0] == CH_G) && (prefix[1] == CH_D2)
                 && (prefix[2] == CH_D8);
  assign p_m11 = (char_index == 2'd3) && (prefix[0] == CH_M) && (prefix[1] == CH_D1)
                 && (prefix[2] == CH_D1);
  assign p_m10 = (char_index == 2'd3) && (prefix[0] == CH_M) && (prefix[1] == CH_D1)
                 && (prefix[2] == CH_D0);
  assign p_g1  = char_index[1] && (prefix[0] == CH_G) && (prefix[1] == CH_D1);
  assign p_m2  = char_index[1] && (prefix[0] == CH_M) && (prefix[1] == CH_D2);
  assign p_m1  = char_index[1] && (prefix[0] == CH_M) && (prefix[1] == CH_D1);
  assign p_m4  = char_index[1] && (prefix[0] == CH_M) && (prefix[1] == CH_D4);

  // Pick the result in priority order of the prefixes.
  always_comb begin
    res_next.cmd_type = CMD_CALIBRATE;
    res_next.status   = ST_OK;
    res_next.arg_a    = '0;
    res_next.arg_b    = '0;
    if (p_m28) begin
      res_next.cmd_type = CMD_CALIBRATE;
    end else if (p_g28) begin
      res_next.cmd_type = CMD_ORIGIN;
    end else if (p_m11) begin
      res_next.cmd_type = CMD_LIMIT;
    end else if (p_g1) begin
      res_next.cmd_type = CMD_MOVE;
      // A value counts only once the space after it has been seen.
      if ((move_phase[1] && x_rep.bad) || (move_done && y_rep.bad)) begin
        res_next.status = ST_BAD_NUM;
      end else begin
        if (move_phase[1]) res_next.arg_a = x_rep.value;
        if (move_done) res_next.arg_b = y_rep.value;
      end
    end else if (p_m10) begin
      res_next.cmd_type = CMD_STATUS;
    end else if (p_m2) begin
      res_next.cmd_type = CMD_PEN_RANGE;
      if (pen_rep.malformed) begin
        res_next.status = ST_MALFORMED;
      end else if (pen_rep.bad) begin
        res_next.status = ST_BAD_NUM;
      end else begin
        res_next.arg_a = pen_rep.up;
        res_next.arg_b = pen_rep.down;
      end
    end else if (p_m1 || p_m4) begin
      res_next.cmd_type = p_m1 ? CMD_PEN : CMD_LASER;
      if (single_rep.bad) res_next.status = ST_BAD_NUM;
      else res_next.arg_a = single_rep.value;
    end else begin
      res_next.status = ST_UNKNOWN;
    end
  end

  // Result register: load on the end of line beat, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.clear) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      result <= res_next;
    end
  end

  // Checks
  `GLCP_ASSERT_NEXT(a_line_end_gives_result, ctl.clear, result_valid, "line end gave no result")
  `GLCP_ASSERT_NEXT(a_line_end_clears, ctl.clear, char_index == 2'd0, "line state not cleared")
  `GLCP_ASSERT_NEXT(a_no_invented_result, !result_valid && !ctl.clear, !result_valid, "result with no line end")
  `GLCP_ASSERT_NOW(a_error_zero_args, result_valid && (result.status != ST_OK), (result.arg_a == '0) && (result.arg_b == '0), "arguments set on an error result")
  `GLCP_ASSERT_NOW(a_unknown_type, result_valid && (result.status == ST_UNKNOWN), result.cmd_type == CMD_CALIBRATE, "unknown command carries a type")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the G-code command line parser.
`timescale 1ns / 100ps

module testbench;
  import glcp_pkg::*;

  // Cycles with no beat on either channel before the run is abandoned. The
  // source gaps and the sink stalls are both drawn by pick_gap and stay far
  // below this limit, so a healthy run never gets near it.
  localparam int STALL_LIMIT = 1000;
  // Magnitude of the most negative 32-bit value; positive values must stay below it.
  localparam logic [63:0] NEG_MAG = 64'd1 << 31;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  gcode_line_command_parser u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction: a private copy of the line state, fed with every beat
  // that the block accepts.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    num_st_t     st;
    logic        neg;
    logic        ovf;
    logic [63:0] mag;
  } scan_num_t;

  int          seen_count;
  logic [7:0]  head_chars[3];
  move_ph_t    mv_phase;
  logic        mv_done;
  scan_num_t   x_num, y_num;
  pr_t         pr_phase;
  scan_num_t   up_num, down_num;
  scan_num_t   arg_num;

  result_t     expected_cmds[$];
  logic [7:0]  line_buf[$];

  int  errors        = 0;
  int  beats_sent    = 0;
  int  lines_sent    = 0;
  int  lines_decoded = 0;
  bit  no_idle       = 1'b0;
  int  stall_left    = 0;
  int  stall_pick;
  int  idle_cycles   = 0;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

  // Fold one digit in, flagging overflow once the magnitude would pass 2^31.
  function automatic scan_num_t push_digit(input scan_num_t a, input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - CH_D0};
    if (!a.ovf) begin
      if (a.mag > (NEG_MAG - d) / 10) a.ovf = 1'b1;
      else a.mag = a.mag * 10 + d;
    end
    return a;
  endfunction

  // Leading whitespace, optional sign, digits; the first non-digit stops it.
  function automatic scan_num_t feed_number(input scan_num_t a, input logic [7:0] c);
    case (a.st)
      NS_LEAD: begin
        if (is_space(c)) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          a.neg = (c == CH_MINUS);
          a.st  = NS_SIGN;
        end else if (is_digit(c)) begin
          a    = push_digit(a, c);
          a.st = NS_DIGS;
        end else begin
          a.st = NS_BAD;
        end
      end
      NS_SIGN: begin
        if (is_digit(c)) begin
          a    = push_digit(a, c);
          a.st = NS_DIGS;
        end else begin
          a.st = NS_BAD;
        end
      end
      NS_DIGS: begin
        if (is_digit(c)) a = push_digit(a, c);
        else a.st = NS_STOP;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic out_of_range(input scan_num_t a);
    return a.ovf || (!a.neg && a.mag >= NEG_MAG);
  endfunction

  function automatic logic number_bad(input scan_num_t a);
    return (a.st != NS_DIGS && a.st != NS_STOP) || out_of_range(a);
  endfunction

  function automatic logic signed [31:0] number_value(input scan_num_t a);
    logic [63:0] v;
    v = a.neg ? (64'd0 - a.mag) : a.mag;
    return v[31:0];
  endfunction

  task automatic clear_decoder();
    seen_count = 0;
    head_chars = '{8'h00, 8'h00, 8'h00};
    mv_phase   = MV_SEEK_X;
    mv_done    = 1'b0;
    x_num      = '0;
    y_num      = '0;
    pr_phase   = PR_WS1;
    up_num     = '0;
    down_num   = '0;
    arg_num    = '0;
  endtask

  // G1: skip to X, take its value up to a space, then the same for Y.
  task automatic feed_move(input logic [7:0] c);
    if (!mv_done) begin
      case (mv_phase)
        MV_SEEK_X: if (c == CH_X) mv_phase = MV_X_DIGS;
        MV_X_DIGS: begin
          if (c == CH_SPACE) mv_phase = MV_SEEK_Y;
          else if (c != CH_DOT) x_num = feed_number(x_num, c);
        end
        MV_SEEK_Y: if (c == CH_Y) mv_phase = MV_Y_DIGS;
        default: begin
          if (c == CH_SPACE) mv_done = 1'b1;
          else if (c != CH_DOT) y_num = feed_number(y_num, c);
        end
      endcase
    end
  endtask

  // M2: [ws] U [ws] [sign] digits [ws] D [ws] [sign] digits, rest ignored.
  task automatic feed_pen_range(input logic [7:0] c);
    case (pr_phase)
      PR_WS1: begin
        if (c == CH_U) pr_phase = PR_UWS;
        else if (!is_space(c)) pr_phase = PR_FAIL;
      end
      PR_UWS: begin
        if (is_space(c)) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          up_num.neg = (c == CH_MINUS);
          pr_phase   = PR_USGN;
        end else if (is_digit(c)) begin
          up_num   = push_digit(up_num, c);
          pr_phase = PR_UDIG;
        end else begin
          pr_phase = PR_FAIL;
        end
      end
      PR_DWS: begin
        if (is_space(c)) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          down_num.neg = (c == CH_MINUS);
          pr_phase     = PR_DSGN;
        end else if (is_digit(c)) begin
          down_num = push_digit(down_num, c);
          pr_phase = PR_DDIG;
        end else begin
          pr_phase = PR_FAIL;
        end
      end
      PR_USGN: begin
        if (is_digit(c)) begin
          up_num   = push_digit(up_num, c);
          pr_phase = PR_UDIG;
        end else begin
          pr_phase = PR_FAIL;
        end
      end
      PR_DSGN: begin
        if (is_digit(c)) begin
          down_num = push_digit(down_num, c);
          pr_phase = PR_DDIG;
        end else begin
          pr_phase = PR_FAIL;
        end
      end
      PR_UDIG: begin
        if (is_digit(c)) up_num = push_digit(up_num, c);
        else if (is_space(c)) pr_phase = PR_WS2;
        else if (c == CH_D) pr_phase = PR_DWS;
        else pr_phase = PR_FAIL;
      end
      PR_WS2: begin
        if (c == CH_D) pr_phase = PR_DWS;
        else if (!is_space(c)) pr_phase = PR_FAIL;
      end
      PR_DDIG: begin
        if (is_digit(c)) down_num = push_digit(down_num, c);
        else pr_phase = PR_DONE;
      end
      default: ;
    endcase
  endtask

  // A prefix only counts when the line holds at least that many characters.
  function automatic logic head_is(input logic [7:0] c0, c1, c2, input int n);
    if (seen_count < n) return 1'b0;
    if (head_chars[0] != c0 || head_chars[1] != c1) return 1'b0;
    return (n < 3) || (head_chars[2] == c2);
  endfunction

  task automatic predict_beat(input item_t beat);
    result_t line_result;
    if (!beat.line_end) begin
      if (seen_count < 3) head_chars[seen_count] = beat.ch;
      feed_move(beat.ch);
      if (seen_count >= 2) begin
        feed_pen_range(beat.ch);
        arg_num = feed_number(arg_num, beat.ch);
      end
      if (seen_count < 3) seen_count++;
    end else begin
      line_result          = '0;
      line_result.cmd_type = CMD_CALIBRATE;
      line_result.status   = ST_OK;
      // Test the prefixes in priority order; the first match decides.
      if (head_is(CH_M, CH_D2, CH_D8, 3)) begin
        line_result.cmd_type = CMD_CALIBRATE;
      end else if (head_is(CH_G, CH_D2, CH_D8, 3)) begin
        line_result.cmd_type = CMD_ORIGIN;
      end else if (head_is(CH_M, CH_D1, CH_D1, 3)) begin
        line_result.cmd_type = CMD_LIMIT;
      end else if (head_is(CH_G, CH_D1, 8'h00, 2)) begin
        line_result.cmd_type = CMD_MOVE;
        if ((mv_phase >= MV_SEEK_Y && number_bad(x_num)) || (mv_done && number_bad(y_num)))
          line_result.status = ST_BAD_NUM;
        else begin
          if (mv_phase >= MV_SEEK_Y) line_result.arg_a = number_value(x_num);
          if (mv_done) line_result.arg_b = number_value(y_num);
        end
      end else if (head_is(CH_M, CH_D1, CH_D0, 3)) begin
        line_result.cmd_type = CMD_STATUS;
      end else if (head_is(CH_M, CH_D2, 8'h00, 2)) begin
        line_result.cmd_type = CMD_PEN_RANGE;
        if (pr_phase != PR_DDIG && pr_phase != PR_DONE)
          line_result.status = ST_MALFORMED;
        else if (out_of_range(up_num) || out_of_range(down_num))
          line_result.status = ST_BAD_NUM;
        else begin
          line_result.arg_a = number_value(up_num);
          line_result.arg_b = number_value(down_num);
        end
      end else if (head_is(CH_M, CH_D1, 8'h00, 2) || head_is(CH_M, CH_D4, 8'h00, 2)) begin
        line_result.cmd_type = (head_chars[1] == CH_D1) ? CMD_PEN : CMD_LASER;
        if (number_bad(arg_num)) line_result.status = ST_BAD_NUM;
        else line_result.arg_a = number_value(arg_num);
      end else begin
        line_result.status = ST_UNKNOWN;
      end
      expected_cmds.push_back(line_result);
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Source side: one beat at a time, with random gaps in front of it.
  // ---------------------------------------------------------------------------
  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input item_t beat);
    int gap;
    gap = pick_gap();
    // Drop valid only when a gap follows; otherwise just swap the payload.
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_beat(beat);
    beats_sent++;
  endtask

  // Send the buffered characters, then the end of line beat with a junk char.
  task automatic send_line();
    item_t beat;
    foreach (line_buf[i]) begin
      beat.ch       = line_buf[i];
      beat.line_end = 1'b0;
      send_beat(beat);
    end
    beat.ch       = 8'($urandom_range(0, 255));
    beat.line_end = 1'b1;
    send_beat(beat);
    line_buf.delete();
    lines_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_text_line(input string s);
    put_text(s);
    send_line();
  endtask

  task automatic put_noise(input int n);
    repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Inside G1 a space ends a value, so only TAB to CR pad there.
  task automatic put_spaces(input bit in_move, input int most);
    int r;
    repeat ($urandom_range(0, most)) begin
      r = in_move ? $urandom_range(9, 13) : $urandom_range(9, 14);
      line_buf.push_back(r == 14 ? CH_SPACE : 8'(r));
    end
  endtask

  // Optional sign and a decimal value: mostly small, some full range, some at
  // the 32-bit edges, some far too long, and now and then no digits at all.
  task automatic put_number(input bit in_move);
    logic [63:0] mag;
    string       digits;
    int          kind;
    if ($urandom_range(0, 3) == 0) put_spaces(in_move, 2);
    case ($urandom_range(0, 3))
      0: line_buf.push_back(CH_PLUS);
      1: line_buf.push_back(CH_MINUS);
      default: ;
    endcase
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4: mag = 64'($urandom_range(0, 999));
      5, 6: mag = 64'($urandom);
      7: begin
        case ($urandom_range(0, 3))
          0: mag = 64'd2147483647;
          1: mag = 64'd2147483648;
          2: mag = 64'd2147483649;
          default: mag = 64'd4294967295;
        endcase
      end
      default: mag = {$urandom, $urandom};
    endcase
    if (kind != 9) begin
      if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_D0);
      digits = $sformatf("%0d", mag);
      for (int i = 0; i < digits.len(); i++) begin
        if (in_move && $urandom_range(0, 5) == 0) line_buf.push_back(CH_DOT);
        line_buf.push_back(digits[i]);
      end
    end
  endtask

  task automatic build_move_line();
    put_text("G1");
    if ($urandom_range(0, 1) == 1) line_buf.push_back(CH_SPACE);
    if ($urandom_range(0, 4) == 0) put_noise($urandom_range(1, 3));
    if ($urandom_range(0, 9) != 0) begin
      line_buf.push_back(CH_X);
      put_number(1'b1);
      if ($urandom_range(0, 7) != 0) line_buf.push_back(CH_SPACE);
    end
    if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 3));
    if ($urandom_range(0, 9) != 0) begin
      line_buf.push_back(CH_Y);
      put_number(1'b1);
      if ($urandom_range(0, 7) != 0) line_buf.push_back(CH_SPACE);
    end
    if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 4));
  endtask

  task automatic build_pen_range_line();
    put_text("M2");
    put_spaces(1'b0, 2);
    line_buf.push_back(CH_U);
    put_number(1'b0);
    put_spaces(1'b0, 2);
    line_buf.push_back(CH_D);
    put_number(1'b0);
    if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 4));
  endtask

  task automatic build_single_arg_line();
    put_text($urandom_range(0, 1) ? "M1" : "M4");
    put_number(1'b0);
    if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 4));
  endtask

  task automatic build_fixed_line();
    case ($urandom_range(0, 3))
      0: put_text("M28");
      1: put_text("G28");
      2: put_text("M11");
      default: put_text("M10");
    endcase
    if ($urandom_range(0, 2) == 0) put_noise($urandom_range(1, 5));
  endtask

  // Mostly well-formed lines with random values; the rest are damaged copies
  // of good lines and plain noise.
  task automatic run_random_lines(input int beats_wanted);
    int first_beat;
    int kind;
    first_beat = beats_sent;
    while (beats_sent - first_beat < beats_wanted) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) build_move_line();
      else if (kind < 50) build_pen_range_line();
      else if (kind < 70) build_single_arg_line();
      else if (kind < 80) build_fixed_line();
      else if (kind < 90) begin
        case ($urandom_range(0, 2))
          0: build_move_line();
          1: build_pen_range_line();
          default: build_single_arg_line();
        endcase
        // Corrupt one character or cut the tail off.
        if ($urandom_range(0, 1) == 1)
          line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        else
          repeat ($urandom_range(1, line_buf.size())) void'(line_buf.pop_back());
      end else begin
        if ($urandom_range(0, 1) == 1) line_buf.push_back($urandom_range(0, 1) ? CH_M : CH_G);
        put_noise($urandom_range(0, 8));
      end
      send_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls on result_ready and a field-by-field check of
  // every result against the oldest pending command.
  // ---------------------------------------------------------------------------
  task automatic field_check(input string name, input logic signed [31:0] want, got);
    if (want !== got) begin
      errors++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    lines_decoded++;
    if (expected_cmds.size() == 0) begin
      errors++;
      $error("result with no line pending: cmd_type %0d status %0d", got.cmd_type, got.status);
    end else begin
      want = expected_cmds.pop_front();
      field_check("cmd_type", want.cmd_type, got.cmd_type);
      field_check("status", want.status, got.status);
      field_check("arg_a", want.arg_a, got.arg_a);
      field_check("arg_b", want.arg_b, got.arg_b);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && result_ready) check_result(result);
      // Hold ready low for the rest of a stall, else maybe start a new one.
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        stall_pick = pick_gap();
        if (stall_pick > 0) begin
          result_ready <= 1'b0;
          stall_left   <= stall_pick - 1;
        end else begin
          result_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: give up when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("[gcode_line_command_parser] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Commands without arguments, prefix priority and unmatched lines.
  task automatic test_prefixes();
    send_text_line("");
    send_text_line("M28");
    send_text_line("G28 X5");
    send_text_line("M11");
    send_text_line("M10");
    send_text_line("M12");
    send_text_line("M29");
    send_text_line("M2");
    send_text_line("M");
    // High bytes and a NUL: nothing matches.
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    line_buf.push_back(8'h00);
    send_line();
  endtask

  // G1: dots dropped, a value counts only once a space ends it, range edges.
  task automatic test_move();
    send_text_line("G1 X12.5 Y-3.0 ");
    send_text_line("G1 X10");
    send_text_line("G1 Xab Y1 ");
    send_text_line("G1 X2147483647 Y-2147483648 ");
    send_text_line("G1 X2147483648 ");
    send_text_line("G1 X-7 Y+2");
  endtask

  // M2: good patterns, an out of range value and a broken pattern.
  task automatic test_pen_range();
    send_text_line("M2 U10 D-20");
    send_text_line("M2U+5D6;");
    send_text_line("M2 U2147483648 D0");
    send_text_line("M2 U1 X");
  endtask

  // M1 and M4: integer from the third character, overflow, no digits, NUL.
  task automatic test_single_arg();
    send_text_line("M1 45");
    send_text_line("M1-2147483648");
    send_text_line("M4 99999999999");
    send_text_line("M4 \t+7xyz");
    send_text_line("M4 +");
    put_text("M1 1");
    line_buf.push_back(8'h00);
    send_text_line("2");
  endtask

  task automatic test_random_with_idling();
    no_idle = 1'b0;
    run_random_lines(1300);
  endtask

  // Full rate on both sides: no source gaps and no sink stalls.
  task automatic test_random_back_to_back();
    no_idle = 1'b1;
    run_random_lines(400);
    no_idle = 1'b0;
  endtask

  initial begin
    clear_decoder();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_prefixes();
    test_move();
    test_pen_range();
    test_single_arg();
    test_random_with_idling();
    test_random_back_to_back();

    // Release the source, drain every pending result, then allow for latency.
    item_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d beats in %0d lines; checked %0d decoded commands.",
             beats_sent, lines_sent, lines_decoded);
    $display("Lines spanned every prefix, G1/M2/M1/M4 arguments, range edges and noise.");
    if (errors == 0) begin
      $display("[gcode_line_command_parser] OK");
    end else begin
      $display("[gcode_line_command_parser] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/glcp_pkg.sv
sv/glcp_digit_acc.sv
sv/glcp_number.sv
sv/glcp_pen_range.sv
sv/gcode_line_command_parser.sv
tb/testbench.sv
